// File: rtl/eesch_pkg.sv
// Shared types and constants of the earliest event scheduler.
package eesch_pkg;

   localparam int TIME_W              = 31;
   localparam int CMD_W               = 3;
   localparam int SLOT_IDX_W          = 4;
   localparam int EVENT_SLOTS_DEFAULT = 16;

   localparam logic [TIME_W-1:0] DISABLED_TIME = {TIME_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_SET    = 3'd0,
      CMD_REBASE = 3'd1,
      CMD_POLL   = 3'd2,
      CMD_START  = 3'd3,
      CMD_STOP   = 3'd4
   } cmd_type;

   // Pass control from the sequencer to the head stage.
   typedef struct packed {
      logic clear;
      logic shift;
      logic do_set;
      logic do_rebase;
   } scan_ctrl_type;

endpackage

// File: rtl/eesch_cell.sv
// One slot cell of the rotating time ring.
module eesch_cell #(
   parameter logic [eesch_pkg::TIME_W-1:0] RESET_TIME = '0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  logic [eesch_pkg::TIME_W-1:0] data_in,
   output logic [eesch_pkg::TIME_W-1:0] data_out
);

   logic [eesch_pkg::TIME_W-1:0] time_ff;
   logic [eesch_pkg::TIME_W-1:0] time_in;

   always_comb begin
      time_in = shift ? data_in : time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= RESET_TIME;
      end else begin
         time_ff <= time_in;
      end
   end

   assign data_out = time_ff;

endmodule

// File: rtl/eesch_scan.sv
// Head stage of the ring: modify the passing slot and track the minimum.
module eesch_scan #(
   parameter int EVENT_SLOTS = eesch_pkg::EVENT_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  eesch_pkg::scan_ctrl_type           ctrl,
   input  logic [eesch_pkg::SLOT_IDX_W-1:0]   slot_index,
   input  logic [eesch_pkg::TIME_W-1:0]       time_value,
   input  logic [eesch_pkg::TIME_W-1:0]       head_in,
   output logic [eesch_pkg::TIME_W-1:0]       head_out,
   output logic                               last,
   output logic [eesch_pkg::TIME_W-1:0]       min_time,
   output logic [$clog2(EVENT_SLOTS)-1:0]     min_slot
);

   localparam int SlotW = $clog2(EVENT_SLOTS);
   localparam int IdxW  = eesch_pkg::SLOT_IDX_W;
   localparam int CmpW  = (SlotW > IdxW) ? SlotW : IdxW;

   logic [SlotW-1:0]             cnt_ff, cnt_in;
   logic [eesch_pkg::TIME_W-1:0] min_ff, min_in;
   logic [SlotW-1:0]             min_slot_ff, min_slot_in;
   logic                         set_hit;

   always_comb begin
      set_hit = ctrl.do_set && (CmpW'(cnt_ff) == CmpW'(slot_index));
      last    = (cnt_ff == SlotW'(EVENT_SLOTS - 1));
      if (set_hit) begin
         head_out = time_value;
      end else if (ctrl.do_rebase && (head_in != eesch_pkg::DISABLED_TIME)) begin
         // saturate at zero on underflow
         head_out = (head_in > time_value) ? (head_in - time_value) : '0;
      end else begin
         head_out = head_in;
      end

      cnt_in      = cnt_ff;
      min_in      = min_ff;
      min_slot_in = min_slot_ff;
      if (ctrl.clear) begin
         cnt_in      = '0;
         min_in      = eesch_pkg::DISABLED_TIME;
         min_slot_in = '0;
      end else if (ctrl.shift) begin
         cnt_in = last ? '0 : cnt_ff + SlotW'(1);
         // strict compare keeps the lowest slot on ties
         if (head_out < min_ff) begin
            min_in      = head_out;
            min_slot_in = cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         min_ff      <= eesch_pkg::DISABLED_TIME;
         min_slot_ff <= '0;
      end else begin
         cnt_ff      <= cnt_in;
         min_ff      <= min_in;
         min_slot_ff <= min_slot_in;
      end
   end

   assign min_time = min_ff;
   assign min_slot = min_slot_ff;

endmodule

// File: rtl/earliest_event_scheduler_top.sv
// Top level of the earliest event scheduler: slot ring, head stage and command sequencer.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------------------
//  request | req_command, req_slot_index, req_time_value   | beat taken when start & !busy
//  result  | rsp_event_due, rsp_due_slot, rsp_next_time,   | beat shown one cycle with
//          | rsp_is_running                                | rsp_valid, always taken
//
//  Each command runs from its accept edge to its result beat as follows: the slot ring
//  rotates one cell per cycle through the single head stage for a full pass of all
//  EVENT_SLOTS cells, then the result is settled in the done state and registered onto
//  the result ports.
//  busy drops in the cycle that shows the result, so the next command may be taken there.
//  Reset is synchronous; the cells load their reset times at once (first and last slot
//  disabled, the rest zero), no clearing pass is needed.
//  The receiver cannot stall: a result beat is lost to nobody, it is held one cycle only.
module earliest_event_scheduler_top #(
   parameter int EVENT_SLOTS = eesch_pkg::EVENT_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [eesch_pkg::CMD_W-1:0]        req_command,
   input  logic [eesch_pkg::SLOT_IDX_W-1:0]   req_slot_index,
   input  logic [eesch_pkg::TIME_W-1:0]       req_time_value,
   output logic                               rsp_valid,
   output logic                               rsp_event_due,
   output logic [eesch_pkg::SLOT_IDX_W-1:0]   rsp_due_slot,
   output logic [eesch_pkg::TIME_W-1:0]       rsp_next_time,
   output logic                               rsp_is_running
);

   localparam int SlotW = $clog2(EVENT_SLOTS);
   localparam int IdxW  = eesch_pkg::SLOT_IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   eesch_pkg::cmd_type             cmd_ff, cmd_in;
   logic [IdxW-1:0]                slot_ff, slot_in;
   logic [eesch_pkg::TIME_W-1:0]   tv_ff, tv_in;
   logic                           running_ff, running_in;
   logic [eesch_pkg::TIME_W-1:0]   earliest_ff, earliest_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_due_ff, rsp_due_in;
   logic [IdxW-1:0]                rsp_slot_ff, rsp_slot_in;
   logic [eesch_pkg::TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   logic                           rsp_run_ff, rsp_run_in;

   logic                           accept;
   eesch_pkg::scan_ctrl_type       ctrl;
   logic                           last;
   logic [eesch_pkg::TIME_W-1:0]   min_time;
   logic [SlotW-1:0]               min_slot;
   logic [eesch_pkg::TIME_W-1:0]   head_out;
   logic [eesch_pkg::TIME_W-1:0]   cell_q [EVENT_SLOTS];

   // Slot ring: each cell takes its upper neighbor, the top cell takes the head output.
   for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
      localparam logic [eesch_pkg::TIME_W-1:0] ResetTime =
         ((i == 0) || (i == EVENT_SLOTS - 1)) ? eesch_pkg::DISABLED_TIME : '0;
      logic [eesch_pkg::TIME_W-1:0] cell_d;
      if (i == EVENT_SLOTS - 1) begin : g_top
         assign cell_d = head_out;
      end else begin : g_mid
         assign cell_d = cell_q[i+1];
      end
      eesch_cell #(
         .RESET_TIME (ResetTime)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (ctrl.shift),
         .data_in  (cell_d),
         .data_out (cell_q[i])
      );
   end

   eesch_scan #(
      .EVENT_SLOTS (EVENT_SLOTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .slot_index (slot_ff),
      .time_value (tv_ff),
      .head_in    (cell_q[0]),
      .head_out   (head_out),
      .last       (last),
      .min_time   (min_time),
      .min_slot   (min_slot)
   );

   always_comb begin
      busy   = (state_ff != ST_IDLE);
      accept = start && !busy;

      // Clear the trackers on accept, then rotate the ring one full turn.
      ctrl.clear     = accept;
      ctrl.shift     = (state_ff == ST_SCAN);
      ctrl.do_set    = ctrl.shift && (cmd_ff == eesch_pkg::CMD_SET);
      ctrl.do_rebase = ctrl.shift && (cmd_ff == eesch_pkg::CMD_REBASE);

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      tv_in        = tv_ff;
      running_in   = running_ff;
      earliest_in  = earliest_ff;
      rsp_valid_in = 1'b0;
      rsp_due_in   = rsp_due_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_run_in   = rsp_run_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = eesch_pkg::cmd_type'(req_command);
               slot_in  = req_slot_index;
               tv_in    = req_time_value;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The pass is complete: the ring is back in place, the minimum is final.
            rsp_due_in  = 1'b0;
            rsp_slot_in = '0;
            case (cmd_ff) inside
               eesch_pkg::CMD_SET, eesch_pkg::CMD_REBASE: begin
                  earliest_in = running_ff ? min_time : '0;
               end
               eesch_pkg::CMD_POLL: begin
                  if (running_ff && (earliest_ff != eesch_pkg::DISABLED_TIME) &&
                      (earliest_ff <= tv_ff)) begin
                     rsp_due_in  = 1'b1;
                     rsp_slot_in = IdxW'(min_slot);
                  end
               end
               eesch_pkg::CMD_START: begin
                  running_in  = 1'b1;
                  earliest_in = min_time;
               end
               eesch_pkg::CMD_STOP: begin
                  running_in  = 1'b0;
                  earliest_in = '0;
               end
               default: begin
                  // unknown command: drop it, report the state unchanged
               end
            endcase
            rsp_time_in  = earliest_in;
            rsp_run_in   = running_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         earliest_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         earliest_ff  <= earliest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      tv_ff       <= tv_in;
      rsp_due_ff  <= rsp_due_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_time_ff <= rsp_time_in;
      rsp_run_ff  <= rsp_run_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_due  = rsp_due_ff;
   assign rsp_due_slot   = rsp_slot_ff;
   assign rsp_next_time  = rsp_time_ff;
   assign rsp_is_running = rsp_run_ff;

endmodule

// File: rtl/eesch_checker.sv
// Port-level checks of the earliest event scheduler and their binding.
module eesch_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic                               rsp_event_due,
   input logic [eesch_pkg::TIME_W-1:0]       rsp_next_time,
   input logic                               rsp_is_running
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted beat");

   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat shown while busy");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_running) |-> (!rsp_event_due && (rsp_next_time == '0)))
      else $error("stopped scheduler reported a time or a due event");

   a_due_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_due) |-> (rsp_next_time != eesch_pkg::DISABLED_TIME))
      else $error("disabled time reported as due");

endmodule

bind earliest_event_scheduler_top eesch_checker u_eesch_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_event_due  (rsp_event_due),
   .rsp_next_time  (rsp_next_time),
   .rsp_is_running (rsp_is_running)
);
